>>> rtl/box_smooth_2x2_macros.svh
// Assertion shorthands shared by the smoothing block.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef BOX_SMOOTH_2X2_MACROS_SVH
`define BOX_SMOOTH_2X2_MACROS_SVH

// Same-cycle implication
`define BS2_HOLDS(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication
`define BS2_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/bs2_pkg.sv
package bs2_pkg;

	// Configuration port
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Internal coordinate width covers the largest frame; ports show 11 bits
	localparam int POS_W     = 13;
	localparam int OUT_POS_W = 11;
	localparam int CH_W      = 8;

	// Result kinds a pixel can release, as bit positions in a job mask
	localparam int NRES     = 4;
	localparam int RES_DIAG = 0;   // up-left pixel, four-point mean
	localparam int RES_UP   = 1;   // pixel above in the last column
	localparam int RES_LEFT = 2;   // left pixel in the last row
	localparam int RES_SELF = 3;   // bottom-right pixel itself

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pix_t;

	// Everything the back end needs to emit the results of one pixel
	typedef struct packed {
		pix_t             above_left;
		pix_t             above;
		pix_t             left;
		pix_t             cur;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic [NRES-1:0]  mask;
	} job_t;

endpackage

>>> rtl/bs2_front.sv
`include "box_smooth_2x2_macros.svh"

module bs2_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bs2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bs2_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bs2_pkg::pix_t                  in_pix,
	output logic                           push,
	output bs2_pkg::job_t                  push_job,
	input  logic                           q_full
);
	import bs2_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	// Last index for a programmed dimension: zero reads as one, large values saturate
	function automatic logic [POS_W-1:0] last_idx(input logic [CFG_DATA_W-1:0] v,
			input int maxv);
		logic [POS_W:0] ext;
		ext = (POS_W+1)'(v);
		if (v == '0)
			return '0;
		if (ext > (POS_W+1)'(maxv))
			return POS_W'(maxv - 1);
		return POS_W'(v - 1'b1);
	endfunction

	localparam logic [POS_W-1:0] WLAST_RST = last_idx(12'd640, MAX_WIDTH);
	localparam logic [POS_W-1:0] HLAST_RST = last_idx(12'd480, MAX_HEIGHT);

	logic [CW-1:0]   wlast_q, col_q;
	logic [RW-1:0]   hlast_q, row_q;
	pix_t            line_mem [MAX_WIDTH];
	pix_t            left_q, above_left_q;
	logic            valid_s1;
	pix_t            cur_s1, left_s1, above_s1;
	logic [RW-1:0]   row_s1;
	logic [CW-1:0]   col_s1;
	logic [NRES-1:0] mask_s1;
	logic [NRES-1:0] mask_d;
	logic            accept, advance_s1;

	// Stage 1 moves on when it has nothing to queue or the queue has room
	assign advance_s1 = valid_s1 && ((mask_s1 == '0) || !q_full);
	assign in_ready   = !valid_s1 || advance_s1;
	assign accept     = in_valid && in_ready;
	assign push       = valid_s1 && (mask_s1 != '0) && !q_full;

	// Classify which results this pixel completes
	always_comb begin
		mask_d           = '0;
		mask_d[RES_DIAG] = (row_q != '0) && (col_q != '0);
		mask_d[RES_UP]   = (row_q != '0) && (col_q == wlast_q);
		mask_d[RES_LEFT] = (row_q == hlast_q) && (col_q != '0);
		mask_d[RES_SELF] = (row_q == hlast_q) && (col_q == wlast_q);
	end

	// Frame size registers and raster position; any listed write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= WLAST_RST[CW-1:0];
			hlast_q <= HLAST_RST[RW-1:0];
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					wlast_q <= CW'(last_idx(cfg_data, MAX_WIDTH));
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					hlast_q <= RW'(last_idx(cfg_data, MAX_HEIGHT));
					col_q   <= '0;
					row_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage 1 occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance_s1)
			valid_s1 <= 1'b0;
	end

	// Capture the pixel and its neighbors held in this row
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1  <= in_pix;
			left_s1 <= left_q;
			row_s1  <= row_q;
			col_s1  <= col_q;
			mask_s1 <= mask_d;
			left_q  <= in_pix;
		end
		if (advance_s1)
			above_left_q <= above_s1;
	end

	// Line buffer: read the previous row's entry, then overwrite it
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1         <= line_mem[col_q];
			line_mem[col_q]  <= in_pix;
		end
	end

	always_comb begin
		push_job            = '0;
		push_job.above_left = above_left_q;
		push_job.above      = above_s1;
		push_job.left       = left_s1;
		push_job.cur        = cur_s1;
		push_job.row        = POS_W'(row_s1);
		push_job.col        = POS_W'(col_s1);
		push_job.mask       = mask_s1;
	end

	`BS2_HOLDS(a_col_in_frame, 1'b1, col_q <= wlast_q, "column counter past row end")

endmodule

>>> rtl/bs2_fifo.sv
`include "box_smooth_2x2_macros.svh"

module bs2_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bs2_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output bs2_pkg::job_t head_job
);
	import bs2_pkg::*;

	localparam int Q_DEPTH = 4;
	localparam int PW      = $clog2(Q_DEPTH);

	job_t          slots_q [Q_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full       = (cnt_q == (PW+1)'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slots_q[rd_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// Store a job on transfer in
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_job;
	end

	`BS2_HOLDS(a_cnt_bound, 1'b1, cnt_q <= (PW+1)'(Q_DEPTH), "queue count overflow")
	`BS2_NEXT(a_cnt_grow, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

>>> rtl/bs2_back.sv
`include "box_smooth_2x2_macros.svh"

module bs2_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  bs2_pkg::job_t                  head_job,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bs2_pkg::pix_t                  out_pix,
	output logic [bs2_pkg::OUT_POS_W-1:0]  out_row,
	output logic [bs2_pkg::OUT_POS_W-1:0]  out_col,
	output logic                           frame_end,
	output logic                           last_of_run
);
	import bs2_pkg::*;

	function automatic chan_t avg4(input chan_t a, input chan_t b, input chan_t c,
			input chan_t d);
		logic [CH_W+1:0] s;
		s = (CH_W+2)'(a) + (CH_W+2)'(b) + (CH_W+2)'(c) + (CH_W+2)'(d);
		return s[CH_W+1:2];
	endfunction

	function automatic chan_t avg2(input chan_t a, input chan_t b);
		logic [CH_W:0] s;
		s = (CH_W+1)'(a) + (CH_W+1)'(b);
		return s[CH_W:1];
	endfunction

	function automatic pix_t mean4(input pix_t a, input pix_t b, input pix_t c,
			input pix_t d);
		pix_t p;
		p.red   = avg4(a.red, b.red, c.red, d.red);
		p.green = avg4(a.green, b.green, c.green, d.green);
		p.blue  = avg4(a.blue, b.blue, c.blue, d.blue);
		return p;
	endfunction

	function automatic pix_t mean2(input pix_t a, input pix_t b);
		pix_t p;
		p.red   = avg2(a.red, b.red);
		p.green = avg2(a.green, b.green);
		p.blue  = avg2(a.blue, b.blue);
		return p;
	endfunction

	logic [NRES-1:0]      done_q, pend, sel, rest;
	logic                 last, load;
	pix_t                 res_pix;
	logic [POS_W-1:0]     res_row, res_col, row_m1, col_m1;
	logic                 out_valid_q, out_frame_end_q, out_last_q;
	pix_t                 out_pix_q;
	logic [OUT_POS_W-1:0] out_row_q, out_col_q;

	// Pick the earliest result of the head job not yet sent
	assign pend = head_valid ? (head_job.mask & ~done_q) : '0;
	assign sel  = pend & (~pend + NRES'(1));
	assign rest = pend & ~sel;
	assign last = (rest == '0);
	assign load = (pend != '0) && (!out_valid_q || out_ready);
	assign pop  = load && last;

	assign row_m1 = head_job.row - POS_W'(1);
	assign col_m1 = head_job.col - POS_W'(1);

	// Form the selected result
	always_comb begin
		if (sel[RES_DIAG]) begin
			res_pix = mean4(head_job.above_left, head_job.above, head_job.left, head_job.cur);
			res_row = row_m1;
			res_col = col_m1;
		end else if (sel[RES_UP]) begin
			res_pix = mean2(head_job.above, head_job.cur);
			res_row = row_m1;
			res_col = head_job.col;
		end else if (sel[RES_LEFT]) begin
			res_pix = mean2(head_job.left, head_job.cur);
			res_row = head_job.row;
			res_col = col_m1;
		end else begin
			res_pix = head_job.cur;
			res_row = head_job.row;
			res_col = head_job.col;
		end
	end

	// Track sent results of the head job; clear when it leaves the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= '0;
		else if (load)
			done_q <= last ? '0 : (done_q | sel);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_pix_q       <= res_pix;
			out_row_q       <= res_row[OUT_POS_W-1:0];
			out_col_q       <= res_col[OUT_POS_W-1:0];
			out_frame_end_q <= sel[RES_SELF];
			out_last_q      <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_pix     = out_pix_q;
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign frame_end   = out_frame_end_q;
	assign last_of_run = out_last_q;

	`BS2_HOLDS(a_done_idle, !head_valid, done_q == '0, "sent marks left without a job")
	`BS2_HOLDS(a_done_in_mask, head_valid, (done_q & ~head_job.mask) == '0, "sent mark outside job")
	`BS2_NEXT(a_frame_end_last, load && sel[RES_SELF], out_frame_end_q && out_last_q,
		"frame end not last of run")

endmodule

>>> rtl/box_smooth_2x2.sv
// 2x2 forward box smoothing of an RGB raster stream. Pixels enter on in_valid/in_ready, one per
// cycle while in_ready is high; each pixel releases zero to four smoothed results, tagged with row
// and column, on out_valid/out_ready. A pixel's results leave one at a time through the output
// register, so row ends and the last row, whose pixels release several results, form bursts that
// a four-entry job queue absorbs. A result passes the stage-1 register, the job queue and the
// output register after the pixel that completes it. The previous row sits in a MAX_WIDTH-entry
// line buffer with one read and one write per accepted pixel and needs no clearing after reset.
// Writing image_width or image_height restarts the frame at row 0, column 0; a size of zero acts
// as one and sizes above MAX_WIDTH or MAX_HEIGHT saturate.
module box_smooth_2x2 #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bs2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bs2_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic [10:0]                    out_row,
	output logic [10:0]                    out_col,
	output logic                           frame_end,
	output logic                           last_of_run
);
	import bs2_pkg::*;

	pix_t in_pix, out_pix;
	logic push, q_full, pop, head_valid;
	job_t push_job, head_job;

	assign in_pix.red   = red_in;
	assign in_pix.green = green_in;
	assign in_pix.blue  = blue_in;

	// Position tracking, line buffer and classification
	bs2_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_pix   (in_pix),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	// Job queue between classification and result expansion
	bs2_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	// Expand each job into its results, one per cycle unless the output is stalled
	bs2_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pix    (out_pix),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_end  (frame_end),
		.last_of_run(last_of_run)
	);

	assign red_out   = out_pix.red;
	assign green_out = out_pix.green;
	assign blue_out  = out_pix.blue;

endmodule
